FILE: hw/rtl/anisotropic_quadratic_failure_check_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the anisotropic quadratic failure check
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ANISOTROPIC_QUADRATIC_FAILURE_CHECK_DEFINES_SVH
`define ANISOTROPIC_QUADRATIC_FAILURE_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AQFC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aqfc check failed");
// next-cycle implication
`define AQFC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aqfc check failed");
`else
`define AQFC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define AQFC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/aqfc_pkg.sv
// ----------------------------------------------------------------------------
// aqfc_pkg
// Shared constants, codes and the configuration bundle.
// ----------------------------------------------------------------------------
package aqfc_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int STRESS_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH      = 4;

  // ratio magnitude bits; saturation value is all ones
  localparam int RATIO_BITS = 30;
  localparam int STR_W      = 31;
  localparam int DIR_W      = 2;
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int OUT_W      = 32;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FAILED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OFF    = 2'd2;

  localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
  localparam logic [DIR_W-1:0] DIR_1   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_2   = 2'd2;
  localparam logic [DIR_W-1:0] DIR_3   = 2'd3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_XT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SL  = 3'd6;

  localparam logic [DIR_W-1:0] DIR_RST = DIR_1;
  localparam logic [STR_W-1:0] STR_RST = 31'd65536;

  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic [STR_W-1:0] xc;
    logic [STR_W-1:0] xt;
    logic [STR_W-1:0] yc;
    logic [STR_W-1:0] yt;
    logic [STR_W-1:0] st;
    logic [STR_W-1:0] sl;
  } cfg_t;

endpackage

FILE: hw/rtl/aqfc_front.sv
// ----------------------------------------------------------------------------
// aqfc_front
// Accepts a node, classifies it and maps stress onto material axes.
// ----------------------------------------------------------------------------
module aqfc_front #(
  parameter int STRESS_WIDTH = aqfc_pkg::STRESS_WIDTH_DEF,
  parameter int ITEM_W = aqfc_pkg::MODE_W + 9 * STRESS_WIDTH + 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  aqfc_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [STRESS_WIDTH-1:0] stress_xx,
  input  logic signed [STRESS_WIDTH-1:0] stress_yy,
  input  logic signed [STRESS_WIDTH-1:0] stress_zz,
  input  logic signed [STRESS_WIDTH-1:0] stress_xy,
  input  logic signed [STRESS_WIDTH-1:0] stress_xz,
  input  logic signed [STRESS_WIDTH-1:0] stress_yz,
  input  logic                           already_failed,
  output logic                           push_valid,
  input  logic                           push_ready,
  output logic [ITEM_W-1:0]              push_data
);
  import aqfc_pkg::*;

  localparam int SW = STRESS_WIDTH;

  logic                 held;
  logic [ITEM_W-1:0]    item;
  logic [MODE_W-1:0]    mode;
  logic signed [SW-1:0] s11, s22, s33, s12, s13, s23;
  logic signed [SW:0]   d23, d31, d12;

  always_comb begin
    s11 = stress_xx; s12 = stress_xy; s13 = stress_xz;
    s22 = stress_yy; s23 = stress_yz; s33 = stress_zz;
    case (cfg.dir)
      DIR_2: begin
        s11 = stress_yy; s12 = stress_xy; s13 = stress_yz;
        s22 = stress_xx; s23 = stress_xz; s33 = stress_zz;
      end
      DIR_3: begin
        s11 = stress_zz; s12 = stress_xz; s13 = stress_yz;
        s22 = stress_xx; s23 = stress_xy; s33 = stress_yy;
      end
      default: begin
      end
    endcase
    if (already_failed) begin
      mode = MODE_FAILED;
    end else if (cfg.dir == DIR_OFF) begin
      mode = MODE_OFF;
    end else begin
      mode = MODE_CHECK;
    end
    d23 = (SW+1)'(s22) - (SW+1)'(s33);
    d31 = (SW+1)'(s33) - (SW+1)'(s11);
    d12 = (SW+1)'(s11) - (SW+1)'(s22);
  end

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_data  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= {mode, s11, s22, s33, s12, s13, s23, d23, d31, d12};
    end
  end

endmodule

FILE: hw/rtl/aqfc_queue.sv
// ----------------------------------------------------------------------------
// aqfc_queue
// Short register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module aqfc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = aqfc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import aqfc_pkg::*;

  `include "anisotropic_quadratic_failure_check_defines.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `AQFC_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `AQFC_ASSERT_NXT(a_cnt_up, clk, rst, push && !pop, count == $past(count) + 1'b1)
  `AQFC_ASSERT_NXT(a_cnt_down, clk, rst, pop && !push, count == $past(count) - 1'b1)

endmodule

FILE: hw/rtl/aqfc_div.sv
// ----------------------------------------------------------------------------
// aqfc_div
// Pipelined saturating ratio v * 2^F / x, one quotient bit per stage.
// ----------------------------------------------------------------------------
module aqfc_div #(
  parameter int VW = 33,
  parameter int F  = aqfc_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [VW-1:0]             v,
  input  logic [aqfc_pkg::STR_W-1:0]       x,
  output logic signed [aqfc_pkg::RATIO_BITS:0] r
);
  import aqfc_pkg::*;

  localparam int RB = RATIO_BITS;
  localparam int NW = VW + F;
  localparam int CW = (NW > RB + STR_W + 1) ? NW + 1 : RB + STR_W + 2;

  logic [VW-1:0] mag;
  logic [CW-1:0] xe, num;
  logic [CW-1:0] rem0;
  logic          neg0, sat0;

  assign xe  = (x == '0) ? CW'(1) : CW'(x);
  assign mag = v[VW-1] ? (~v + 1'b1) : v;
  assign num = CW'(mag) << F;

  always_ff @(posedge clk) begin
    if (en) begin
      rem0 <= num;
      neg0 <= v[VW-1];
      sat0 <= num >= (xe << RB);
    end
  end

  logic [CW-1:0] rem_s [0:RB-1];
  logic [RB-1:0] q_s   [0:RB-1];
  logic          neg_s [0:RB-1];
  logic          sat_s [0:RB-1];

  for (genvar i = 0; i < RB; i++) begin : g_stage
    localparam int B = RB - 1 - i;
    logic [CW-1:0] rem_in, dsh;
    logic [RB-1:0] q_in;
    logic          neg_in, sat_in, ge;
    if (i == 0) begin : g_first
      assign rem_in = rem0;
      assign q_in   = '0;
      assign neg_in = neg0;
      assign sat_in = sat0;
    end else begin : g_next
      assign rem_in = rem_s[i-1];
      assign q_in   = q_s[i-1];
      assign neg_in = neg_s[i-1];
      assign sat_in = sat_s[i-1];
    end
    assign dsh = xe << B;
    assign ge  = rem_in >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i] <= ge ? rem_in - dsh : rem_in;
        q_s[i]   <= {q_in[RB-2:0], ge};
        neg_s[i] <= neg_in;
        sat_s[i] <= sat_in;
      end
    end
  end

  logic [RB-1:0] qmag;
  assign qmag = sat_s[RB-1] ? '1 : q_s[RB-1];

  always_ff @(posedge clk) begin
    if (en) begin
      r <= neg_s[RB-1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end
  end

endmodule

FILE: hw/rtl/aqfc_sqrt.sv
// ----------------------------------------------------------------------------
// aqfc_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module aqfc_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [aqfc_pkg::RAD_W-1:0]  n,
  output logic [aqfc_pkg::ROOT_W-1:0] root
);
  import aqfc_pkg::*;

  logic [RAD_W-1:0] n_s [0:ROOT_W-1];
  logic [RAD_W-1:0] r_s [0:ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int SH = RAD_W - 2 - 2 * k;
    logic [RAD_W-1:0] n_in, r_in, bitv, trial;
    logic             ge;
    if (k == 0) begin : g_first
      assign n_in = n;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_s[k-1];
      assign r_in = r_s[k-1];
    end
    assign bitv  = RAD_W'(1) << SH;
    assign trial = r_in + bitv;
    assign ge    = n_in >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        n_s[k] <= ge ? n_in - trial : n_in;
        r_s[k] <= ge ? (r_in >> 1) + bitv : r_in >> 1;
      end
    end
  end

  assign root = r_s[ROOT_W-1][ROOT_W-1:0];

endmodule

FILE: hw/rtl/aqfc_back.sv
// ----------------------------------------------------------------------------
// aqfc_back
// Evaluates the criterion in one stalling pipeline and holds the result.
// ----------------------------------------------------------------------------
module aqfc_back #(
  parameter int FRAC_BITS    = aqfc_pkg::FRAC_BITS_DEF,
  parameter int STRESS_WIDTH = aqfc_pkg::STRESS_WIDTH_DEF,
  parameter int ITEM_W = aqfc_pkg::MODE_W + 9 * STRESS_WIDTH + 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  aqfc_pkg::cfg_t                    cfg,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  logic [ITEM_W-1:0]                 pop_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              failed,
  output logic signed [aqfc_pkg::OUT_W-1:0] criterion_value
);
  import aqfc_pkg::*;

  `include "anisotropic_quadratic_failure_check_defines.svh"

  localparam int SW      = STRESS_WIDTH;
  localparam int RB      = RATIO_BITS;
  localparam int NR      = 17;
  localparam int DIV_LAT = RB + 2;
  localparam int LIN_W   = RB + 3;
  localparam int SQ_W    = 2 * RB;
  localparam int FW      = ROOT_W + 3;
  localparam logic [FW-1:0] ONE_Q = FW'(1) << FRAC_BITS;

  // ratio slots
  localparam int R_D23_YC = 0,  R_D23_YT = 1,  R_D23_XC = 2,  R_D23_XT = 3;
  localparam int R_D31_XC = 4,  R_D31_XT = 5,  R_D12_XC = 6,  R_D12_XT = 7;
  localparam int R_S23_ST = 8,  R_S13_SL = 9,  R_S12_SL = 10;
  localparam int R_S11_XT = 11, R_S11_XC = 12, R_S22_YT = 13, R_S22_YC = 14;
  localparam int R_S33_YT = 15, R_S33_YC = 16;

  function automatic logic signed [RB:0] avg_tz(input logic signed [RB:0] a,
                                                input logic signed [RB:0] b);
    logic signed [RB+1:0] s;
    s = (RB+2)'(a) + (RB+2)'(b);
    s = s + $signed({{(RB+1){1'b0}}, s[RB+1]});
    return s[RB+1:1];
  endfunction

  logic en;
  assign en        = !out_valid || out_ready;
  assign pop_ready = en;

  // unpack the queued item
  logic [MODE_W-1:0]    p_mode;
  logic signed [SW-1:0] p11, p22, p33, p12, p13, p23;
  logic signed [SW:0]   p_d23, p_d31, p_d12;
  assign {p_mode, p11, p22, p33, p12, p13, p23, p_d23, p_d31, p_d12} = pop_data;

  logic signed [SW:0]    div_v [0:NR-1];
  logic [STR_W-1:0]      div_x [0:NR-1];
  logic signed [RB:0]    rv    [0:NR-1];

  always_comb begin
    div_v[R_D23_YC] = p_d23;     div_x[R_D23_YC] = cfg.yc;
    div_v[R_D23_YT] = p_d23;     div_x[R_D23_YT] = cfg.yt;
    div_v[R_D23_XC] = p_d23;     div_x[R_D23_XC] = cfg.xc;
    div_v[R_D23_XT] = p_d23;     div_x[R_D23_XT] = cfg.xt;
    div_v[R_D31_XC] = p_d31;     div_x[R_D31_XC] = cfg.xc;
    div_v[R_D31_XT] = p_d31;     div_x[R_D31_XT] = cfg.xt;
    div_v[R_D12_XC] = p_d12;     div_x[R_D12_XC] = cfg.xc;
    div_v[R_D12_XT] = p_d12;     div_x[R_D12_XT] = cfg.xt;
    div_v[R_S23_ST] = (SW+1)'(p23); div_x[R_S23_ST] = cfg.st;
    div_v[R_S13_SL] = (SW+1)'(p13); div_x[R_S13_SL] = cfg.sl;
    div_v[R_S12_SL] = (SW+1)'(p12); div_x[R_S12_SL] = cfg.sl;
    div_v[R_S11_XT] = (SW+1)'(p11); div_x[R_S11_XT] = cfg.xt;
    div_v[R_S11_XC] = (SW+1)'(p11); div_x[R_S11_XC] = cfg.xc;
    div_v[R_S22_YT] = (SW+1)'(p22); div_x[R_S22_YT] = cfg.yt;
    div_v[R_S22_YC] = (SW+1)'(p22); div_x[R_S22_YC] = cfg.yc;
    div_v[R_S33_YT] = (SW+1)'(p33); div_x[R_S33_YT] = cfg.yt;
    div_v[R_S33_YC] = (SW+1)'(p33); div_x[R_S33_YC] = cfg.yc;
  end

  for (genvar k = 0; k < NR; k++) begin : g_div
    aqfc_div #(.VW(SW + 1), .F(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .v   (div_v[k]),
      .x   (div_x[k]),
      .r   (rv[k])
    );
  end

  // valid and mode ride alongside the dividers
  logic              dv [0:DIV_LAT-1];
  logic [MODE_W-1:0] dm [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) dv[k] <= 1'b0;
    end else if (en) begin
      dv[0] <= pop_valid;
      for (int k = 1; k < DIV_LAT; k++) dv[k] <= dv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm[0] <= p_mode;
      for (int k = 1; k < DIV_LAT; k++) dm[k] <= dm[k-1];
    end
  end

  // C1: averaged ratios and the linear sum
  logic                    c1_v;
  logic [MODE_W-1:0]       c1_m;
  logic signed [RB:0]      c1_a [0:6];
  logic signed [LIN_W-1:0] c1_lin;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_m    <= dm[DIV_LAT-1];
      c1_a[0] <= avg_tz(rv[R_D23_YC], rv[R_D23_YT]);
      c1_a[1] <= avg_tz(rv[R_D23_XC], rv[R_D23_XT]);
      c1_a[2] <= avg_tz(rv[R_D31_XC], rv[R_D31_XT]);
      c1_a[3] <= avg_tz(rv[R_D12_XC], rv[R_D12_XT]);
      c1_a[4] <= rv[R_S23_ST];
      c1_a[5] <= rv[R_S13_SL];
      c1_a[6] <= rv[R_S12_SL];
      c1_lin  <= LIN_W'(avg_tz(rv[R_S11_XT], -rv[R_S11_XC]))
               + LIN_W'(avg_tz(rv[R_S22_YT], -rv[R_S22_YC]))
               + LIN_W'(avg_tz(rv[R_S33_YT], -rv[R_S33_YC]));
    end
  end

  // C2: squares
  logic                    c2_v;
  logic [MODE_W-1:0]       c2_m;
  logic [SQ_W-1:0]         c2_sq [0:6];
  logic signed [LIN_W-1:0] c2_lin;
  logic signed [2*RB+1:0]  prod  [0:6];

  always_comb begin
    for (int k = 0; k < 7; k++) prod[k] = c1_a[k] * c1_a[k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_m   <= c1_m;
      c2_lin <= c1_lin;
      for (int k = 0; k < 7; k++) c2_sq[k] <= prod[k][SQ_W-1:0];
    end
  end

  // C3: partial sums, halved terms floor
  logic                    c3_v;
  logic [MODE_W-1:0]       c3_m;
  logic signed [RAD_W-1:0] c3_sa, c3_sb, c3_sc;
  logic signed [LIN_W-1:0] c3_lin;

  always_ff @(posedge clk) begin
    if (en) begin
      c3_m   <= c2_m;
      c3_lin <= c2_lin;
      c3_sa  <= $signed(RAD_W'(c2_sq[0])) - $signed(RAD_W'(c2_sq[1] >> 1))
              + $signed(RAD_W'(c2_sq[2] >> 1));
      c3_sb  <= $signed(RAD_W'(c2_sq[3] >> 1)) + $signed(RAD_W'(c2_sq[4]));
      c3_sc  <= $signed(RAD_W'(c2_sq[5])) + $signed(RAD_W'(c2_sq[6]));
    end
  end

  // C4: radicand
  logic                    c4_v;
  logic [MODE_W-1:0]       c4_m;
  logic                    c4_neg;
  logic [RAD_W-1:0]        c4_n;
  logic signed [LIN_W-1:0] c4_lin;
  logic signed [RAD_W-1:0] qsum;

  assign qsum = c3_sa + c3_sb + c3_sc;

  always_ff @(posedge clk) begin
    if (en) begin
      c4_m   <= c3_m;
      c4_lin <= c3_lin;
      c4_neg <= qsum[RAD_W-1];
      c4_n   <= qsum[RAD_W-1] ? '0 : qsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      c3_v <= 1'b0;
      c4_v <= 1'b0;
    end else if (en) begin
      c1_v <= dv[DIV_LAT-1];
      c2_v <= c1_v;
      c3_v <= c2_v;
      c4_v <= c3_v;
    end
  end

  logic [ROOT_W-1:0] root;

  aqfc_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    (c4_n),
    .root (root)
  );

  // side line matching the root pipeline
  logic                    sv  [0:ROOT_W-1];
  logic [MODE_W-1:0]       sm  [0:ROOT_W-1];
  logic                    sng [0:ROOT_W-1];
  logic signed [LIN_W-1:0] sl  [0:ROOT_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROOT_W; k++) sv[k] <= 1'b0;
    end else if (en) begin
      sv[0] <= c4_v;
      for (int k = 1; k < ROOT_W; k++) sv[k] <= sv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm[0]  <= c4_m;
      sng[0] <= c4_neg;
      sl[0]  <= c4_lin;
      for (int k = 1; k < ROOT_W; k++) begin
        sm[k]  <= sm[k-1];
        sng[k] <= sng[k-1];
        sl[k]  <= sl[k-1];
      end
    end
  end

  // final sum, decision and saturation
  logic signed [FW-1:0]    f_w;
  logic                    fits;
  logic signed [OUT_W-1:0] f_sat;
  logic                    res_failed;
  logic signed [OUT_W-1:0] res_value;

  always_comb begin
    f_w  = $signed({3'b000, root}) + FW'(sl[ROOT_W-1]) - $signed(ONE_Q);
    fits = (f_w[FW-1:OUT_W-1] == '0) || (f_w[FW-1:OUT_W-1] == '1);
    if (fits) begin
      f_sat = f_w[OUT_W-1:0];
    end else if (f_w[FW-1]) begin
      f_sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      f_sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
    case (sm[ROOT_W-1])
      MODE_FAILED: begin
        res_failed = 1'b1;
        res_value  = '0;
      end
      MODE_CHECK: begin
        if (sng[ROOT_W-1]) begin
          res_failed = 1'b0;
          res_value  = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
          res_failed = !f_w[FW-1] && (f_w != '0);
          res_value  = f_sat;
        end
      end
      default: begin
        res_failed = 1'b0;
        res_value  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      failed          <= res_failed;
      criterion_value <= res_value;
    end
  end

  `AQFC_ASSERT_IMP(a_fail_sign, clk, rst, out_valid && failed, !criterion_value[OUT_W-1])
  `AQFC_ASSERT_NXT(a_stall_hold, clk, rst, !en, $stable({c1_v, c2_v, c3_v, c4_v}))

endmodule

FILE: hw/rtl/anisotropic_quadratic_failure_check.sv
// ----------------------------------------------------------------------------
// anisotropic_quadratic_failure_check
// Hoffman-type anisotropic failure check for one mesh node per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries six stress components (signed, FRAC_BITS
// fraction bits) and an already-failed flag; each produces exactly one output
// transfer with the updated failed flag and the saturated 32-bit criterion
// f = sqrt(Qf) + linear terms - 1. The block takes one node per clock when
// the output side is ready. From input transfer to result a node passes
// the front register, a queue slot, the seventeen ratio dividers (one
// quotient bit per stage), the averaging, squaring and summing registers,
// the root pipeline (one bit per stage) and the output register. The front
// and the back are split by a four-entry queue, so the front keeps taking
// nodes while the back is held by the output side, until the queue is full;
// the back pipeline stalls as a whole while its output register holds an
// untaken result. Configuration is a plain write port:
// cfg_we with cfg_index 0 sets fiber_direction (1..3 selects the axis
// permutation, 0 disables the check), indices 1..6 set Xc, Xt, Yc, Yt, St
// and S. Write only while idle. A strength written as zero acts as one.
// ----------------------------------------------------------------------------
module anisotropic_quadratic_failure_check #(
  parameter int FRAC_BITS    = aqfc_pkg::FRAC_BITS_DEF,
  parameter int STRESS_WIDTH = aqfc_pkg::STRESS_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [aqfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aqfc_pkg::STR_W-1:0]            cfg_data,
  // node input
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [STRESS_WIDTH-1:0]        stress_xx,
  input  logic signed [STRESS_WIDTH-1:0]        stress_yy,
  input  logic signed [STRESS_WIDTH-1:0]        stress_zz,
  input  logic signed [STRESS_WIDTH-1:0]        stress_xy,
  input  logic signed [STRESS_WIDTH-1:0]        stress_xz,
  input  logic signed [STRESS_WIDTH-1:0]        stress_yz,
  input  logic                                  already_failed,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  failed,
  output logic signed [aqfc_pkg::OUT_W-1:0]     criterion_value
);
  import aqfc_pkg::*;

  // mode, six stresses and three differences one bit wider
  localparam int ITEM_W = MODE_W + 9 * STRESS_WIDTH + 3;

  cfg_t cfg;

  // configuration registers; writes to unknown indices drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dir <= DIR_RST;
      cfg.xc  <= STR_RST;
      cfg.xt  <= STR_RST;
      cfg.yc  <= STR_RST;
      cfg.yt  <= STR_RST;
      cfg.st  <= STR_RST;
      cfg.sl  <= STR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIR: cfg.dir <= cfg_data[DIR_W-1:0];
        CFG_XC:  cfg.xc  <= cfg_data;
        CFG_XT:  cfg.xt  <= cfg_data;
        CFG_YC:  cfg.yc  <= cfg_data;
        CFG_YT:  cfg.yt  <= cfg_data;
        CFG_ST:  cfg.st  <= cfg_data;
        CFG_SL:  cfg.sl  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic              f_valid, f_ready;
  logic [ITEM_W-1:0] f_data;
  logic              b_valid, b_ready;
  logic [ITEM_W-1:0] b_data;

  // front: accept, classify, permute axes, form differences
  aqfc_front #(.STRESS_WIDTH(STRESS_WIDTH), .ITEM_W(ITEM_W)) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .stress_xx      (stress_xx),
    .stress_yy      (stress_yy),
    .stress_zz      (stress_zz),
    .stress_xy      (stress_xy),
    .stress_xz      (stress_xz),
    .stress_yz      (stress_yz),
    .already_failed (already_failed),
    .push_valid     (f_valid),
    .push_ready     (f_ready),
    .push_data      (f_data)
  );

  // decoupling queue
  aqfc_queue #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  // back: ratios, quadratic form, root, decision, output register
  aqfc_back #(
    .FRAC_BITS    (FRAC_BITS),
    .STRESS_WIDTH (STRESS_WIDTH),
    .ITEM_W       (ITEM_W)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .pop_valid       (b_valid),
    .pop_ready       (b_ready),
    .pop_data        (b_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .failed          (failed),
    .criterion_value (criterion_value)
  );

endmodule
